FILE: rtl/core/tccc_pkg.sv
// Shared types and constants for the text console cursor control unit.
// Used by every module in rtl/core; it has no dependencies of its own.
`default_nettype none

package tccc_pkg;

  localparam int unsigned ColW  = 8;
  localparam int unsigned RowW  = 7;
  localparam int unsigned CharW = 8;
  localparam int unsigned ClrW  = 24;

  localparam logic [ColW-1:0]  COLS_RESET = 8'd128;
  localparam logic [RowW-1:0]  ROWS_RESET = 7'd48;
  localparam logic [ColW-1:0]  TAB_CELLS  = 8'd4;

  localparam logic [CharW-1:0] CH_BS     = 8'd8;
  localparam logic [CharW-1:0] CH_TAB    = 8'd9;
  localparam logic [CharW-1:0] CH_LF     = 8'd10;
  localparam logic [CharW-1:0] CH_VT     = 8'd11;
  localparam logic [CharW-1:0] CH_CR     = 8'd13;
  localparam logic [CharW-1:0] CH_SPACE  = 8'd32;
  localparam logic [CharW-1:0] CH_TILDE  = 8'd126;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_GLYPH = 2'd1,
    ACT_FILL  = 2'd2
  } action_t;

  typedef enum logic {
    REG_COLS = 1'b0,
    REG_ROWS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [ColW-1:0] cols;
    logic [RowW-1:0] rows;
  } cfg_t;

  typedef struct packed {
    action_t          action;
    logic [ColW-1:0]  cell_col;
    logic [RowW-1:0]  cell_row;
    logic [CharW-1:0] glyph_code;
    logic [ColW-1:0]  span_len;
    logic [ClrW-1:0]  draw_fg;
    logic [ClrW-1:0]  draw_bg;
    logic             scroll_before;
    logic             scroll_after;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/tccc_cfg.sv
// Configuration register file with an APB-style slave port.
// Holds the screen size in columns and rows; depends on tccc_pkg.
`default_nettype none

module tccc_cfg
  import tccc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_COLS: cfg_nxt.cols = pwdata[ColW-1:0];
        REG_ROWS: cfg_nxt.rows = pwdata[RowW-1:0];
        default:  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COLS: prdata = {{(32-ColW){1'b0}}, cfg_r.cols};
      REG_ROWS: prdata = {{(32-RowW){1'b0}}, cfg_r.rows};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cols <= COLS_RESET;
      cfg_r.rows <= ROWS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tccc_step.sv
// Cursor and control-character logic for one character.
// Builds the draw command and the next cursor position; depends on tccc_pkg.
`default_nettype none

module tccc_step
  import tccc_pkg::*;
(
  input  cfg_t                   cfg,
  input  wire logic [ColW-1:0]   cur_col,
  input  wire logic [RowW-1:0]   cur_row,
  input  wire logic [CharW-1:0]  char_in,
  input  wire logic [ClrW-1:0]   fg_color,
  input  wire logic [ClrW-1:0]   bg_color,
  output cmd_t                   cmd,
  output logic      [ColW-1:0]   col_nxt,
  output logic      [RowW-1:0]   row_nxt
);

  logic [ColW-1:0] w;
  logic [RowW:0]   h;
  logic            wrap;
  logic [ColW-1:0] c1, c3, left, tab_n;
  logic [RowW:0]   r1, r2, r3;
  logic            sb, sa;
  action_t         act;
  logic [CharW-1:0] glyph;
  logic [ColW-1:0] span;
  logic [ColW-1:0] ccol;
  logic [RowW:0]   crow;

  assign w = (cfg.cols == '0) ? ColW'(1) : cfg.cols;
  assign h = (cfg.rows == '0) ? (RowW+1)'(1) : {1'b0, cfg.rows};

  // A cursor parked past the last column wraps to the next row first.
  assign wrap = cur_col >= w;
  assign c1   = wrap ? '0 : cur_col;
  assign r1   = {1'b0, cur_row} + (RowW+1)'(wrap);
  assign sb   = r1 >= h;
  assign r2   = sb ? h - (RowW+1)'(1) : r1;

  assign left  = w - c1;
  assign tab_n = (left > TAB_CELLS) ? TAB_CELLS : left;

  always_comb begin
    c3    = c1;
    r3    = r2;
    act   = ACT_NONE;
    glyph = '0;
    span  = '0;
    ccol  = '0;
    crow  = '0;
    unique case (char_in)
      CH_LF: begin
        act   = ACT_FILL;
        ccol  = c1;
        crow  = r2;
        glyph = CH_SPACE;
        span  = left;
        c3    = '0;
        r3    = r2 + (RowW+1)'(1);
      end
      CH_TAB: begin
        act   = ACT_FILL;
        ccol  = c1;
        crow  = r2;
        glyph = CH_SPACE;
        span  = tab_n;
        c3    = c1 + tab_n;
      end
      CH_VT: begin
        r3 = r2 + (RowW+1)'(1);
      end
      CH_CR: begin
        c3 = '0;
      end
      CH_BS: begin
        if (c1 != '0) begin
          c3 = c1 - ColW'(1);
        end else if (r2 != '0) begin
          r3 = r2 - (RowW+1)'(1);
          c3 = w - ColW'(1);
        end
        act   = ACT_GLYPH;
        ccol  = c3;
        crow  = r3;
        glyph = CH_SPACE;
        span  = ColW'(1);
      end
      default: begin
        if (char_in >= CH_SPACE && char_in <= CH_TILDE) begin
          act   = ACT_GLYPH;
          ccol  = c1;
          crow  = r2;
          glyph = char_in;
          span  = ColW'(1);
          c3    = c1 + ColW'(1);
        end
      end
    endcase
  end

  assign sa      = r3 >= h;
  assign col_nxt = c3;
  assign row_nxt = sa ? RowW'(h - (RowW+1)'(1)) : r3[RowW-1:0];

  always_comb begin
    cmd.action        = act;
    cmd.cell_col      = ccol;
    cmd.cell_row      = crow[RowW-1:0];
    cmd.glyph_code    = glyph;
    cmd.span_len      = span;
    cmd.draw_fg       = (act == ACT_NONE) ? '0 : fg_color;
    cmd.draw_bg       = (act == ACT_NONE) ? '0 : bg_color;
    cmd.scroll_before = sb;
    cmd.scroll_after  = sa;
  end

endmodule

`default_nettype wire

FILE: rtl/core/text_console_cursor_control_unit.sv
// Top level of the text console cursor control unit.
// Instantiates tccc_cfg and tccc_step; depends on tccc_pkg.
//
// Each input transaction carries one character with its foreground and
// background colors. For every input transaction the unit delivers exactly
// one output transaction: a draw command (nothing, one glyph, or a span of
// spaces) at a cell position, plus flags that tell whether the screen scrolls
// up one row before or after the draw. Control characters move the cursor.
// The character is captured in an input register, the cursor logic between
// the registers is combinational, and the command lands in an output register;
// out_valid rises when the command is loaded there. One character is taken
// per cycle while out_stall is low; the combinational cursor update between
// the two registers sets that rate. When out_stall is high the output
// register holds its command, and the input register still accepts one more
// character before in_stall rises. Reset clears the cursor to column 0, row 0,
// empties both registers and sets the screen size to 128 columns by 48 rows.
// The size registers sit at byte addresses 0 (columns) and 4 (rows); the user
// writes them only while idle, and the block itself does not enforce this.
`default_nettype none

module text_console_cursor_control_unit
  import tccc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CharW-1:0]  in_char_in,
  input  wire logic [ClrW-1:0]   in_fg_color,
  input  wire logic [ClrW-1:0]   in_bg_color,

  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [1:0]        out_action,
  output logic      [ColW-1:0]   out_cell_col,
  output logic      [RowW-1:0]   out_cell_row,
  output logic      [CharW-1:0]  out_glyph_code,
  output logic      [ColW-1:0]   out_span_len,
  output logic      [ClrW-1:0]   out_draw_fg,
  output logic      [ClrW-1:0]   out_draw_bg,
  output logic                   out_scroll_before,
  output logic                   out_scroll_after,

  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  cfg_t             cfg;
  cmd_t             cmd;
  cmd_t             cmd_r;
  logic [ColW-1:0]  col_nxt, cursor_col_r;
  logic [RowW-1:0]  row_nxt, cursor_row_r;
  logic             in_v_r, out_v_r;
  logic [CharW-1:0] char_r;
  logic [ClrW-1:0]  fg_r, bg_r;
  logic             adv, in_acc;

  tccc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tccc_step u_step (
    .cfg      (cfg),
    .cur_col  (cursor_col_r),
    .cur_row  (cursor_row_r),
    .char_in  (char_r),
    .fg_color (fg_r),
    .bg_color (bg_r),
    .cmd      (cmd),
    .col_nxt  (col_nxt),
    .row_nxt  (row_nxt)
  );

  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
    end else begin
      if (in_acc) begin
        in_v_r <= 1'b1;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r      <= 1'b1;
        cursor_col_r <= col_nxt;
        cursor_row_r <= row_nxt;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      char_r <= in_char_in;
      fg_r   <= in_fg_color;
      bg_r   <= in_bg_color;
    end
    if (adv) begin
      cmd_r <= cmd;
    end
  end

  assign out_valid         = out_v_r;
  assign out_action        = cmd_r.action;
  assign out_cell_col      = cmd_r.cell_col;
  assign out_cell_row      = cmd_r.cell_row;
  assign out_glyph_code    = cmd_r.glyph_code;
  assign out_span_len      = cmd_r.span_len;
  assign out_draw_fg       = cmd_r.draw_fg;
  assign out_draw_bg       = cmd_r.draw_bg;
  assign out_scroll_before = cmd_r.scroll_before;
  assign out_scroll_after  = cmd_r.scroll_after;

  // The next cursor row always lies on the screen.
  a_row_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r |-> (row_nxt < cfg.rows) || (row_nxt == '0))
    else $error("next cursor row is below the screen");

  // The cursor moves only when a character passes to the output register.
  a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(cursor_col_r) && $stable(cursor_row_r))
    else $error("cursor moved without a transaction");

  // A command with nothing drawn carries zero payload.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (cmd_r.action == ACT_NONE) |->
      (cmd_r.span_len == '0) && (cmd_r.draw_fg == '0) && (cmd_r.draw_bg == '0))
    else $error("empty command carries payload");

  // A fill command always covers at least one cell.
  a_fill_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (cmd_r.action == ACT_FILL) |-> (cmd_r.span_len != '0))
    else $error("fill command with empty span");

endmodule

`default_nettype wire

FILE: tb/tb_text_console_cursor_control_unit.sv
// Self-checking testbench for text_console_cursor_control_unit.
// It predicts every draw command from its own cursor model and checks each output
// transaction. It depends only on tccc_pkg and the unit itself.
`default_nettype none

module tb_text_console_cursor_control_unit
  import tccc_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [CharW-1:0] in_char_in;
  logic [ClrW-1:0]  in_fg_color;
  logic [ClrW-1:0]  in_bg_color;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       out_action;
  logic [ColW-1:0]  out_cell_col;
  logic [RowW-1:0]  out_cell_row;
  logic [CharW-1:0] out_glyph_code;
  logic [ColW-1:0]  out_span_len;
  logic [ClrW-1:0]  out_draw_fg;
  logic [ClrW-1:0]  out_draw_bg;
  logic             out_scroll_before;
  logic             out_scroll_after;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  logic [ColW-1:0]  cols_cfg = COLS_RESET;
  logic [RowW-1:0]  rows_cfg = ROWS_RESET;
  logic [ColW-1:0]  cursor_col = '0;
  logic [RowW-1:0]  cursor_row = '0;
  cmd_t             pending_cmds[$];
  cmd_t             exp_cmd;
  int               err_cnt = 0;
  int               cycle_cnt = 0;
  int               hold_left = 0;
  bit               idle_en = 1'b1;

  text_console_cursor_control_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_char_in(in_char_in),
    .in_fg_color(in_fg_color), .in_bg_color(in_bg_color),
    .out_valid(out_valid), .out_stall(out_stall), .out_action(out_action),
    .out_cell_col(out_cell_col), .out_cell_row(out_cell_row),
    .out_glyph_code(out_glyph_code), .out_span_len(out_span_len),
    .out_draw_fg(out_draw_fg), .out_draw_bg(out_draw_bg),
    .out_scroll_before(out_scroll_before), .out_scroll_after(out_scroll_after),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The cursor advances, wraps and scrolls exactly as the unit should for one character.
  function automatic cmd_t predict_draw_cmd(logic [CharW-1:0] ch, logic [ClrW-1:0] fg,
                                            logic [ClrW-1:0] bg);
    cmd_t c;
    int   w;
    int   h;
    int   col;
    int   row;
    int   n;
    c   = '0;
    w   = (cols_cfg == 0) ? 1 : int'(cols_cfg);
    h   = (rows_cfg == 0) ? 1 : int'(rows_cfg);
    col = int'(cursor_col);
    row = int'(cursor_row);
    if (col >= w) begin
      col = 0;
      row = row + 1;
    end
    if (row >= h) begin
      c.scroll_before = 1'b1;
      row = h - 1;
    end
    case (ch)
      CH_LF: begin
        c.action     = ACT_FILL;
        c.cell_col   = 8'(col);
        c.cell_row   = 7'(row);
        c.glyph_code = CH_SPACE;
        c.span_len   = 8'(w - col);
        col = 0;
        row = row + 1;
      end
      CH_TAB: begin
        n = w - col;
        if (n > int'(TAB_CELLS)) n = int'(TAB_CELLS);
        c.action     = ACT_FILL;
        c.cell_col   = 8'(col);
        c.cell_row   = 7'(row);
        c.glyph_code = CH_SPACE;
        c.span_len   = 8'(n);
        col = col + n;
      end
      CH_VT: row = row + 1;
      CH_CR: col = 0;
      CH_BS: begin
        if (col > 0) begin
          col = col - 1;
        end else if (row > 0) begin
          row = row - 1;
          col = w - 1;
        end
        c.action     = ACT_GLYPH;
        c.cell_col   = 8'(col);
        c.cell_row   = 7'(row);
        c.glyph_code = CH_SPACE;
        c.span_len   = 8'd1;
      end
      default: begin
        if (ch >= CH_SPACE && ch <= CH_TILDE) begin
          c.action     = ACT_GLYPH;
          c.cell_col   = 8'(col);
          c.cell_row   = 7'(row);
          c.glyph_code = ch;
          c.span_len   = 8'd1;
          col = col + 1;
        end
      end
    endcase
    if (c.action != ACT_NONE) begin
      c.draw_fg = fg;
      c.draw_bg = bg;
    end
    if (row >= h) begin
      c.scroll_after = 1'b1;
      row = h - 1;
    end
    cursor_col = 8'(col);
    cursor_row = 7'(row);
    return c;
  endfunction

  function automatic logic [CharW-1:0] rand_char();
    logic [CharW-1:0] ctl[5];
    int               r;
    ctl = '{CH_BS, CH_TAB, CH_LF, CH_VT, CH_CR};
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(32, 126));
    if (r < 85) return ctl[$urandom_range(0, 4)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_char(logic [CharW-1:0] ch, logic [ClrW-1:0] fg, logic [ClrW-1:0] bg);
    if (idle_en && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_char_in  <= ch;
    in_fg_color <= fg;
    in_bg_color <= bg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_cmds.push_back(predict_draw_cmd(ch, fg, bg));
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      send_char(rand_char(), 24'($urandom), 24'($urandom));
    end
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_COLS) cols_cfg = value;
    else rows_cfg = value[RowW-1:0];
  endtask

  task automatic set_screen(logic [ColW-1:0] cols, logic [RowW-1:0] rows);
    wait_results_done();
    write_reg(REG_COLS, cols);
    write_reg(REG_ROWS, {1'b0, rows});
  endtask

  task automatic test_default_screen();
    send_char(CH_BS, 24'($urandom), 24'($urandom));
    send_char("A", 24'hFFFFFF, 24'h000000);
    send_char(CH_SPACE, 24'h000000, 24'hFFFFFF);
    send_char(CH_TILDE, 24'($urandom), 24'($urandom));
    send_char(8'd0, 24'hFFFFFF, 24'hFFFFFF);
    send_char(8'd31, 24'($urandom), 24'($urandom));
    send_char(8'd127, 24'($urandom), 24'($urandom));
    send_char(8'd255, 24'hFFFFFF, 24'hFFFFFF);
    send_char(CH_TAB, 24'($urandom), 24'($urandom));
    send_char(CH_CR, 24'($urandom), 24'($urandom));
    send_char(CH_VT, 24'($urandom), 24'($urandom));
    send_char(CH_LF, 24'($urandom), 24'($urandom));
    send_char(CH_BS, 24'($urandom), 24'($urandom));
    send_char(CH_CR, 24'($urandom), 24'($urandom));
  endtask

  // A five by two screen makes the pending wrap and both scroll flags show up quickly.
  task automatic test_small_screen();
    string s;
    s = "abcde";
    set_screen(8'd5, 7'd2);
    foreach (s[i]) send_char(s[i], 24'($urandom), 24'($urandom));
    send_char(CH_TAB, 24'($urandom), 24'($urandom));
    send_char("x", 24'($urandom), 24'($urandom));
    send_char(CH_LF, 24'($urandom), 24'($urandom));
  endtask

  task automatic test_zero_size();
    set_screen(8'd0, 7'd0);
    send_char("q", 24'($urandom), 24'($urandom));
    send_char(CH_BS, 24'($urandom), 24'($urandom));
    send_char(CH_TAB, 24'($urandom), 24'($urandom));
  endtask

  task automatic test_full_screen();
    idle_en = 1'b0;
    set_screen(8'd255, 7'd127);
    send_random(300);
    idle_en = 1'b1;
  endtask

  task automatic test_single_row();
    set_screen(8'd255, 7'd1);
    send_random(120);
  endtask

  task automatic test_tiny_screens();
    for (int i = 0; i < 4; i++) begin
      set_screen(8'($urandom_range(1, 8)), 7'($urandom_range(1, 4)));
      send_random(100);
    end
    set_screen(8'd1, 7'd1);
    send_random(50);
  endtask

  task automatic test_backpressure();
    set_screen(8'd40, 7'd6);
    hold_left = HOLD_CYCLES;
    send_random(40);
    wait_results_done();
    send_random(40);
  endtask

  task automatic test_random_sizes();
    set_screen(COLS_RESET, ROWS_RESET);
    send_random(150);
    for (int i = 0; i < 3; i++) begin
      set_screen(8'($urandom_range(1, 255)), 7'($urandom_range(1, 127)));
      send_random(60);
    end
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= idle_en && ($urandom_range(0, 99) < 7);
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      err_cnt++;
      if (err_cnt <= 10) $display("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("Output transaction with no command expected");
      end else begin
        exp_cmd = pending_cmds.pop_front();
        check_field("action", exp_cmd.action, out_action);
        check_field("cell_col", exp_cmd.cell_col, out_cell_col);
        check_field("cell_row", exp_cmd.cell_row, out_cell_row);
        check_field("glyph_code", exp_cmd.glyph_code, out_glyph_code);
        check_field("span_len", exp_cmd.span_len, out_span_len);
        check_field("draw_fg", exp_cmd.draw_fg, out_draw_fg);
        check_field("draw_bg", exp_cmd.draw_bg, out_draw_bg);
        check_field("scroll_before", exp_cmd.scroll_before, out_scroll_before);
        check_field("scroll_after", exp_cmd.scroll_after, out_scroll_after);
      end
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_char_in  <= '0;
    in_fg_color <= '0;
    in_bg_color <= '0;
    out_stall   <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_screen();
    test_small_screen();
    test_zero_size();
    test_full_screen();
    test_single_row();
    test_tiny_screens();
    test_backpressure();
    test_random_sizes();
    wait_results_done();
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && pending_cmds.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
